// ===== hdl/ctl_pkg.sv =====
`default_nettype none

package ctl_pkg;

  // Counter width for the length and whitespace counts.
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Result queue geometry between the lexer front and the output stage.
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  // Token kinds.
  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_NAME    = 5'd1;
  localparam logic [4:0] K_INT     = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_COMMENT = 5'd4;
  localparam logic [4:0] K_STAR    = 5'd5;
  localparam logic [4:0] K_SLASH   = 5'd6;
  localparam logic [4:0] K_PLUS    = 5'd7;
  localparam logic [4:0] K_PLUS2   = 5'd8;
  localparam logic [4:0] K_MINUS   = 5'd9;
  localparam logic [4:0] K_MINUS2  = 5'd10;
  localparam logic [4:0] K_LT      = 5'd11;
  localparam logic [4:0] K_SHL     = 5'd12;
  localparam logic [4:0] K_GT      = 5'd13;
  localparam logic [4:0] K_SHR     = 5'd14;
  localparam logic [4:0] K_NOT     = 5'd15;
  localparam logic [4:0] K_XOR     = 5'd16;
  localparam logic [4:0] K_AND     = 5'd17;
  localparam logic [4:0] K_LAND    = 5'd18;
  localparam logic [4:0] K_OR      = 5'd19;
  localparam logic [4:0] K_LOR     = 5'd20;
  localparam logic [4:0] K_JUNK    = 5'd21;

  // Lexer modes. The six pair-operator modes start at M_PAIR in table order.
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_NAME       = 4'd1;
  localparam logic [3:0] M_INT        = 4'd2;
  localparam logic [3:0] M_STR        = 4'd3;
  localparam logic [3:0] M_STR_ESC    = 4'd4;
  localparam logic [3:0] M_SLASH      = 4'd5;
  localparam logic [3:0] M_BLOCK      = 4'd6;
  localparam logic [3:0] M_BLOCK_STAR = 4'd7;
  localparam logic [3:0] M_LINE       = 4'd8;
  localparam logic [3:0] M_JUNK       = 4'd9;
  localparam logic [3:0] M_PAIR       = 4'd10;
  localparam int NPAIR = 6;

  // Byte constants.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // One reported token.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] length;
    logic [15:0] white;
    logic        clipped;
  } ctl_rec_t;

  // Everything one input byte produces: one or two tokens.
  typedef struct packed {
    logic     two;
    ctl_rec_t r0;
    ctl_rec_t r1;
  } ctl_entry_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_USCORE;
  endfunction

  function automatic logic is_numeral(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Operator characters that may double up.
  function automatic logic [7:0] pair_ch(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h2D;
      3'd2:    c = 8'h3C;
      3'd3:    c = 8'h3E;
      3'd4:    c = 8'h26;
      3'd5:    c = 8'h7C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] pair_single(logic [2:0] i);
    logic [4:0] k;
    case (i)
      3'd0:    k = K_PLUS;
      3'd1:    k = K_MINUS;
      3'd2:    k = K_LT;
      3'd3:    k = K_GT;
      3'd4:    k = K_AND;
      3'd5:    k = K_OR;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_double(logic [2:0] i);
    logic [4:0] k;
    case (i)
      3'd0:    k = K_PLUS2;
      3'd1:    k = K_MINUS2;
      3'd2:    k = K_SHL;
      3'd3:    k = K_SHR;
      3'd4:    k = K_LAND;
      3'd5:    k = K_LOR;
      default: k = K_END;
    endcase
    return k;
  endfunction

  // Kind reported when end of text closes an open token.
  function automatic logic [4:0] closing_kind(logic [3:0] m);
    logic [4:0] k;
    logic [3:0] d;
    d = m - M_PAIR;
    case (m)
      M_NAME:                        k = K_NAME;
      M_INT:                         k = K_INT;
      M_STR, M_STR_ESC:              k = K_STRING;
      M_SLASH:                       k = K_SLASH;
      M_BLOCK, M_BLOCK_STAR, M_LINE: k = K_COMMENT;
      M_JUNK:                        k = K_JUNK;
      default: begin
        if (m >= M_PAIR) k = pair_single(d[2:0]);
        else k = K_END;
      end
    endcase
    return k;
  endfunction

  // Counts are reported as their low 16 bits.
  function automatic logic [15:0] fit16(logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic ctl_rec_t mk_rec(logic [4:0] kind, logic [COUNT_BITS-1:0] len,
                                      logic [COUNT_BITS-1:0] wh, logic sat);
    ctl_rec_t r;
    r.kind    = kind;
    r.length  = fit16(len);
    r.white   = fit16(wh);
    r.clipped = sat;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ctl_front.sv =====
`default_nettype none

module ctl_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_op,
  input  wire logic [7:0]          in_text_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output ctl_pkg::ctl_entry_t      q_din
);

  logic [3:0]                     mode_r, mode_nxt;
  logic [ctl_pkg::COUNT_BITS-1:0] len_r, len_nxt;
  logic [ctl_pkg::COUNT_BITS-1:0] white_r, white_nxt;
  logic                           sat_r, sat_nxt;

  logic             fin_a, fin_b, pass;
  logic [4:0]       kind_a, kind_b;
  logic [2:0]       pidx;
  logic [3:0]       pdiff;
  ctl_pkg::ctl_rec_t rec_a, rec_b;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pdiff    = mode_r - ctl_pkg::M_PAIR;
  assign pidx     = pdiff[2:0];

  // Next-state and token logic for one byte: first the open token may close,
  // then the byte may start a new token (which may close at once).
  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    white_nxt = white_r;
    sat_nxt   = sat_r;
    fin_a     = 1'b0;
    fin_b     = 1'b0;
    kind_a    = ctl_pkg::K_END;
    kind_b    = ctl_pkg::K_END;
    pass      = 1'b0;
    rec_a     = '0;
    rec_b     = '0;

    if (in_op) begin
      if (mode_r != ctl_pkg::M_IDLE) begin
        fin_a  = 1'b1;
        kind_a = ctl_pkg::closing_kind(mode_r);
      end
    end else begin
      case (mode_r)
        ctl_pkg::M_NAME: begin
          if (ctl_pkg::is_letter(in_text_byte) || ctl_pkg::is_numeral(in_text_byte)) begin
            if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
            else sat_nxt = 1'b1;
          end else begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_NAME; pass = 1'b1;
          end
        end
        ctl_pkg::M_INT: begin
          if (ctl_pkg::is_numeral(in_text_byte)) begin
            if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
            else sat_nxt = 1'b1;
          end else begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_INT; pass = 1'b1;
          end
        end
        ctl_pkg::M_STR: begin
          if (in_text_byte < ctl_pkg::CH_SPACE) begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_STRING; pass = 1'b1;
          end else begin
            if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
            else sat_nxt = 1'b1;
            if (in_text_byte == ctl_pkg::CH_QUOTE) begin
              fin_a = 1'b1; kind_a = ctl_pkg::K_STRING;
            end else if (in_text_byte == ctl_pkg::CH_BSL) begin
              mode_nxt = ctl_pkg::M_STR_ESC;
            end
          end
        end
        ctl_pkg::M_STR_ESC: begin
          if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
          else sat_nxt = 1'b1;
          mode_nxt = ctl_pkg::M_STR;
        end
        ctl_pkg::M_SLASH: begin
          if (in_text_byte == ctl_pkg::CH_STAR || in_text_byte == ctl_pkg::CH_SLASH) begin
            if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
            else sat_nxt = 1'b1;
            mode_nxt = (in_text_byte == ctl_pkg::CH_STAR) ? ctl_pkg::M_BLOCK
                                                          : ctl_pkg::M_LINE;
          end else begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_SLASH; pass = 1'b1;
          end
        end
        ctl_pkg::M_BLOCK: begin
          if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
          else sat_nxt = 1'b1;
          if (in_text_byte == ctl_pkg::CH_STAR) mode_nxt = ctl_pkg::M_BLOCK_STAR;
        end
        ctl_pkg::M_BLOCK_STAR: begin
          if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
          else sat_nxt = 1'b1;
          if (in_text_byte == ctl_pkg::CH_SLASH) begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_COMMENT;
          end else if (in_text_byte != ctl_pkg::CH_STAR) begin
            mode_nxt = ctl_pkg::M_BLOCK;
          end
        end
        ctl_pkg::M_LINE: begin
          if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
          else sat_nxt = 1'b1;
          if (in_text_byte == ctl_pkg::CH_NL) begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_COMMENT;
          end
        end
        ctl_pkg::M_JUNK: begin
          if (in_text_byte[7:6] == 2'b10) begin
            if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
            else sat_nxt = 1'b1;
          end else begin
            fin_a = 1'b1; kind_a = ctl_pkg::K_JUNK; pass = 1'b1;
          end
        end
        default: begin
          if (mode_r >= ctl_pkg::M_PAIR) begin
            if (in_text_byte == ctl_pkg::pair_ch(pidx)) begin
              if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
              else sat_nxt = 1'b1;
              fin_a = 1'b1; kind_a = ctl_pkg::pair_double(pidx);
            end else begin
              fin_a = 1'b1; kind_a = ctl_pkg::pair_single(pidx); pass = 1'b1;
            end
          end else begin
            mode_nxt = ctl_pkg::M_IDLE;
            pass     = 1'b1;
          end
        end
      endcase
    end

    // Close the open token and clear the counts.
    if (fin_a) begin
      rec_a     = ctl_pkg::mk_rec(kind_a, len_nxt, white_nxt, sat_nxt);
      len_nxt   = '0;
      white_nxt = '0;
      sat_nxt   = 1'b0;
      mode_nxt  = ctl_pkg::M_IDLE;
    end

    // End of text always closes with an end token.
    if (in_op) begin
      fin_b  = 1'b1;
      kind_b = ctl_pkg::K_END;
    end

    // The ending byte starts the next token or its whitespace.
    if (pass) begin
      if (in_text_byte <= ctl_pkg::CH_SPACE) begin
        if (white_nxt != ctl_pkg::COUNT_MAX) white_nxt = white_nxt + 1'b1;
        else sat_nxt = 1'b1;
      end
      if (len_nxt != ctl_pkg::COUNT_MAX) len_nxt = len_nxt + 1'b1;
      else sat_nxt = 1'b1;
      if (in_text_byte > ctl_pkg::CH_SPACE) begin
        if (ctl_pkg::is_letter(in_text_byte)) mode_nxt = ctl_pkg::M_NAME;
        else if (ctl_pkg::is_numeral(in_text_byte)) mode_nxt = ctl_pkg::M_INT;
        else if (in_text_byte == ctl_pkg::CH_QUOTE) mode_nxt = ctl_pkg::M_STR;
        else if (in_text_byte == ctl_pkg::CH_STAR) begin
          fin_b = 1'b1; kind_b = ctl_pkg::K_STAR;
        end else if (in_text_byte == ctl_pkg::CH_BANG) begin
          fin_b = 1'b1; kind_b = ctl_pkg::K_NOT;
        end else if (in_text_byte == ctl_pkg::CH_CARET) begin
          fin_b = 1'b1; kind_b = ctl_pkg::K_XOR;
        end else if (in_text_byte == ctl_pkg::CH_SLASH) begin
          mode_nxt = ctl_pkg::M_SLASH;
        end else begin
          mode_nxt = ctl_pkg::M_JUNK;
          for (int i = 0; i < ctl_pkg::NPAIR; i++) begin
            if (in_text_byte == ctl_pkg::pair_ch(3'(i))) mode_nxt = ctl_pkg::M_PAIR + 4'(i);
          end
        end
      end
    end

    // Close the token that started or ended on this byte.
    if (fin_b) begin
      rec_b     = ctl_pkg::mk_rec(kind_b, len_nxt, white_nxt, sat_nxt);
      len_nxt   = '0;
      white_nxt = '0;
      sat_nxt   = 1'b0;
      mode_nxt  = ctl_pkg::M_IDLE;
    end
  end

  // Pack the tokens of this byte for the queue.
  assign q_push   = accept && (fin_a || fin_b);
  assign q_din.two = fin_a && fin_b;
  assign q_din.r0  = fin_a ? rec_a : rec_b;
  assign q_din.r1  = rec_b;

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctl_pkg::M_IDLE;
      len_r   <= '0;
      white_r <= '0;
      sat_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      white_r <= white_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ctl_queue.sv =====
`default_nettype none

module ctl_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ctl_pkg::ctl_entry_t din,
  output logic                     full,
  output logic                     head_valid,
  output ctl_pkg::ctl_entry_t      head,
  input  wire logic                pop
);

  ctl_pkg::ctl_entry_t      mem_r [ctl_pkg::QDEPTH];
  logic [ctl_pkg::QAW-1:0]  wr_r, rd_r;
  logic [ctl_pkg::QAW:0]    cnt_r;

  assign full       = cnt_r == (ctl_pkg::QAW+1)'(ctl_pkg::QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  // Pointers and fill count; pointers wrap at the power-of-two depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ctl_back.sv =====
`default_nettype none

module ctl_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire ctl_pkg::ctl_entry_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [4:0]               out_token_kind,
  output logic [15:0]              out_token_length,
  output logic [15:0]              out_leading_white,
  output logic                     out_clipped,
  output logic                     out_last_of_run
);

  ctl_pkg::ctl_entry_t ent_r;
  ctl_pkg::ctl_rec_t   cur;
  logic                busy_r, idx_r;
  logic                last_c, xfer;

  assign last_c = idx_r || !ent_r.two;
  assign xfer   = busy_r && out_ready;
  assign pop    = head_valid && (!busy_r || (xfer && last_c));

  // Present the first or second token of the held entry.
  assign cur               = idx_r ? ent_r.r1 : ent_r.r0;
  assign out_valid         = busy_r;
  assign out_token_kind    = cur.kind;
  assign out_token_length  = cur.length;
  assign out_leading_white = cur.white;
  assign out_clipped       = cur.clipped;
  assign out_last_of_run   = last_c;

  // Output holding register.
  always_ff @(posedge clk) begin
    if (pop) ent_r <= head;
  end

  // Track whether a token is on show and which one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 1'b0;
    end else if (xfer && last_c) begin
      busy_r <= 1'b0;
      idx_r  <= 1'b0;
    end else if (xfer) begin
      idx_r <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/c_style_token_lexer.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_op, in_text_byte
// out     | out_valid / out_ready| out_token_kind, out_token_length,
//         |                      | out_leading_white, out_clipped, out_last_of_run
//
// One byte is taken per cycle unless the queue is full; the lexer front updates
// its mode and counts in the cycle of the transfer. A byte's tokens pass through
// the queue into the output holding register and appear on the output one token
// per cycle while out_ready is high. A four-entry queue between the front and the
// output register absorbs output stalls; in_ready drops only when that queue is full.
// Reset is synchronous and returns the lexer to idle with zero counts.
`default_nettype none

module c_style_token_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_token_length,
  output logic [15:0]      out_leading_white,
  output logic             out_clipped,
  output logic             out_last_of_run
);

  ctl_pkg::ctl_entry_t q_din, q_head;
  logic                q_push, q_full, q_head_valid, q_pop;

  ctl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_din        (q_din)
  );

  ctl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .din        (q_din),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  ctl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head              (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_token_length  (out_token_length),
    .out_leading_white (out_leading_white),
    .out_clipped       (out_clipped),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== hdl/ctl_chk.sv =====
`default_nettype none

module ctl_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  out_token_kind,
  input wire logic [15:0] out_token_length,
  input wire logic [15:0] out_leading_white,
  input wire logic        out_clipped,
  input wire logic        out_last_of_run
);

  // A stalled token holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_length) && $stable(out_last_of_run))
    else $error("stalled token changed");

  // The second token of a byte follows right after the first.
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("second token of a byte did not follow");

  // Whitespace is always counted inside the token length.
  a_white_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_leading_white <= out_token_length)
    else $error("whitespace count exceeds token length");

  // Only defined kinds are reported.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= ctl_pkg::K_JUNK)
    else $error("undefined token kind");

  // An end token that follows a closed token within the same byte is empty.
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run && out_token_kind != ctl_pkg::K_END |=>
    out_token_kind != ctl_pkg::K_END || (out_token_length == 16'd0 && !out_clipped))
    else $error("end token after a closed token is not empty");

endmodule

bind c_style_token_lexer ctl_chk u_chk (.*);

`default_nettype wire
